// File: src/vmfe_pkg.sv
// ----------------------------------------------------------------------------
// vmfe_pkg
// Shared types and constants for the Euler-angle view matrix builder.
// ----------------------------------------------------------------------------
`default_nettype none

package vmfe_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ZW           = 35;   // residual angle, Q30 plus range headroom
    localparam int XW           = 34;   // CORDIC x/y, Q2.30 plus growth

    localparam logic signed [ZW-1:0] Q30_PI       = 35'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI  = 35'sd1686629713;
    localparam logic signed [XW-1:0] CORDIC_K     = 34'sh26DD3B6A;
    localparam logic signed [31:0]   ONE_Q16      = 32'sh0001_0000;
    localparam logic        [1:0]    LAST_COL     = 2'd3;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } pos_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
    } item_t;

    typedef struct packed {
        logic        [1:0]  column_index;
        logic signed [31:0] entry_row0;
        logic signed [31:0] entry_row1;
        logic signed [31:0] entry_row2;
        logic signed [31:0] entry_row3;
        logic               last_column;
    } column_t;

    // Truncated Q30 arctangent of 2^-i
    function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
        logic signed [ZW-1:0] r;
        unique case (i)
            0:  r = 35'sh3243F6A8;
            1:  r = 35'sh1DAC6705;
            2:  r = 35'sh0FADBAFC;
            3:  r = 35'sh07F56EA6;
            4:  r = 35'sh03FEAB76;
            5:  r = 35'sh01FFD55B;
            6:  r = 35'sh00FFFAAA;
            7:  r = 35'sh007FFF55;
            8:  r = 35'sh003FFFEA;
            9:  r = 35'sh001FFFFD;
            10: r = 35'sh000FFFFF;
            11: r = 35'sh0007FFFF;
            12: r = 35'sh0003FFFF;
            13: r = 35'sh0001FFFF;
            14: r = 35'sh0000FFFF;
            15: r = 35'sh00007FFF;
            16: r = 35'sh00003FFF;
            17: r = 35'sh00001FFF;
            18: r = 35'sh00000FFF;
            19: r = 35'sh000007FF;
            20: r = 35'sh000003FF;
            21: r = 35'sh000001FF;
            22: r = 35'sh000000FF;
            23: r = 35'sh0000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Round a Q32.32 sum half up to Q16.16 and saturate to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [64:0] s);
        logic signed [64:0] t;
        t = (s + 65'sd32768) >>> 16;
        if (t > 65'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (t < -65'sd2147483648)
            return 32'sh8000_0000;
        else
            return 32'(t);
    endfunction

endpackage

`default_nettype wire

// File: src/vmfe_cordic.sv
// ----------------------------------------------------------------------------
// vmfe_cordic
// Pipelined rotation-mode CORDIC: one range-reduction stage, then one
// register stage per iteration. Sine and cosine come out rounded to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module vmfe_cordic
    import vmfe_pkg::*;
(
    input  wire                clk,
    input  wire                en,
    input  wire signed [15:0]  angle,
    output logic signed [31:0] sin_val,
    output logic signed [31:0] cos_val
);

    logic signed [XW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [XW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS+1];
    logic                 neg_reg [CORDIC_STEPS+1];

    logic signed [ZW-1:0] z_in;
    logic signed [ZW-1:0] z_red;
    logic                 neg_in;

    always_comb
    begin
        z_in = {{(ZW-33){angle[15]}}, angle, 17'b0};
        priority if (z_in > Q30_HALF_PI)
        begin
            z_red  = z_in - Q30_PI;
            neg_in = 1'b1;
        end
        else if (z_in < -Q30_HALF_PI)
        begin
            z_red  = z_in + Q30_PI;
            neg_in = 1'b1;
        end
        else
        begin
            z_red  = z_in;
            neg_in = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_K;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_red;
            neg_reg[0] <= neg_in;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    logic signed [XW-1:0] x_rnd;
    logic signed [XW-1:0] y_rnd;
    logic signed [XW-1:0] c_fix;
    logic signed [XW-1:0] s_fix;

    always_comb
    begin
        x_rnd = (x_reg[CORDIC_STEPS] + XW'(8192)) >>> 14;
        y_rnd = (y_reg[CORDIC_STEPS] + XW'(8192)) >>> 14;
        c_fix = neg_reg[CORDIC_STEPS] ? -x_rnd : x_rnd;
        s_fix = neg_reg[CORDIC_STEPS] ? -y_rnd : y_rnd;
        cos_val = 32'(c_fix);
        sin_val = 32'(s_fix);
    end

endmodule

`default_nettype wire

// File: src/view_matrix_from_euler_angles.sv
// ----------------------------------------------------------------------------
// view_matrix_from_euler_angles
// Builds the model-view matrix T*Rz*Ry*Rx from a position and three angles.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel takes a position (Q16.16) and three angles (Q3.13
//   radians). For every accepted transaction the column channel sends four
//   transactions, columns 0 to 3 in order, last_column set on column 3.
//   An item passes 31 registers (25 CORDIC stages, 5 matrix-product
//   stages, one output register); the first column is presented when the
//   item is loaded into the output register. The other columns follow on
//   the next cycles unless stalled.
//   The single column channel carries four columns per item and so bounds
//   the sustained item rate. Items may be offered every cycle; the pipeline
//   holds them while the output register drains.
//   Stall: when the output register is still busy with an earlier matrix
//   and the last pipeline stage is full, the whole pipeline freezes and
//   item_stall rises; nothing is lost or repeated.
//   Reset: all valid bits clear, no column is pending, the block is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module view_matrix_from_euler_angles
    import vmfe_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  wire      item_valid,
    output logic     item_stall,
    input  item_t    item,
    output logic     column_valid,
    input  wire      column_stall,
    output column_t  column
);

    localparam int SA  = CORDIC_STEPS + 1;   // sine/cosine registered
    localparam int SB  = SA + 1;             // first products
    localparam int SC  = SB + 1;             // Rz*Ry
    localparam int SD  = SC + 1;             // second products
    localparam int SE  = SD + 1;             // rotation matrix
    localparam int NST = SE + 1;

    logic       v_reg [NST];
    pos_t       pos_reg [NST];
    logic       adv;
    logic       load;
    logic       fire;
    logic       done;

    logic       ser_valid_reg;
    logic [1:0] col_reg;

    // ---- sine / cosine -----------------------------------------------------
    logic signed [31:0] sx, cx, sy, cy, sz, cz;

    vmfe_cordic u_cordic_x (.clk(clk), .en(adv), .angle(item.angle_x),
                            .sin_val(sx), .cos_val(cx));
    vmfe_cordic u_cordic_y (.clk(clk), .en(adv), .angle(item.angle_y),
                            .sin_val(sy), .cos_val(cy));
    vmfe_cordic u_cordic_z (.clk(clk), .en(adv), .angle(item.angle_z),
                            .sin_val(sz), .cos_val(cz));

    // ---- valid and position line -------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= item_valid;
            for (int k = 1; k < NST; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_reg[0] <= '{pos_x: item.pos_x, pos_y: item.pos_y, pos_z: item.pos_z};
            for (int k = 1; k < NST; k++)
                pos_reg[k] <= pos_reg[k-1];
        end
    end

    // ---- matrix products ---------------------------------------------------
    logic signed [31:0] sx_a_reg, cx_a_reg, sy_a_reg, cy_a_reg, sz_a_reg, cz_a_reg;
    logic signed [63:0] b_czcy_reg, b_nszcy_reg, b_nczsy_reg, b_szsy_reg;
    logic signed [31:0] sx_b_reg, cx_b_reg, sy_b_reg, cy_b_reg, sz_b_reg, cz_b_reg;
    logic signed [31:0] zy0_reg [3];
    logic signed [31:0] zy1_reg [3];
    logic signed [31:0] zy2_reg [3];
    logic signed [31:0] sx_c_reg, nsx_c_reg, cx_c_reg;
    logic signed [31:0] zy0_d_reg [3];
    logic signed [63:0] m1a_reg [3];
    logic signed [63:0] m1b_reg [3];
    logic signed [63:0] m2a_reg [3];
    logic signed [63:0] m2b_reg [3];
    logic signed [31:0] r0_reg [3];
    logic signed [31:0] r1_reg [3];
    logic signed [31:0] r2_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage A
            sx_a_reg <= sx;  cx_a_reg <= cx;
            sy_a_reg <= sy;  cy_a_reg <= cy;
            sz_a_reg <= sz;  cz_a_reg <= cz;
            // stage B
            b_czcy_reg  <= 64'(cz_a_reg) * 64'(cy_a_reg);
            b_nszcy_reg <= 64'(-sz_a_reg) * 64'(cy_a_reg);
            b_nczsy_reg <= 64'(-cz_a_reg) * 64'(sy_a_reg);
            b_szsy_reg  <= 64'(sz_a_reg) * 64'(sy_a_reg);
            sx_b_reg <= sx_a_reg;  cx_b_reg <= cx_a_reg;
            sy_b_reg <= sy_a_reg;  cy_b_reg <= cy_a_reg;
            sz_b_reg <= sz_a_reg;  cz_b_reg <= cz_a_reg;
            // stage C: Rz*Ry
            zy0_reg[0] <= round_sat(65'(b_czcy_reg));
            zy0_reg[1] <= round_sat(65'(b_nszcy_reg));
            zy0_reg[2] <= sy_b_reg;
            zy1_reg[0] <= sz_b_reg;
            zy1_reg[1] <= cz_b_reg;
            zy1_reg[2] <= '0;
            zy2_reg[0] <= round_sat(65'(b_nczsy_reg));
            zy2_reg[1] <= round_sat(65'(b_szsy_reg));
            zy2_reg[2] <= cy_b_reg;
            sx_c_reg  <= sx_b_reg;
            nsx_c_reg <= -sx_b_reg;
            cx_c_reg  <= cx_b_reg;
            // stages D and E: (Rz*Ry)*Rx
            for (int r = 0; r < 3; r++)
            begin
                zy0_d_reg[r] <= zy0_reg[r];
                m1a_reg[r]   <= 64'(zy1_reg[r]) * 64'(cx_c_reg);
                m1b_reg[r]   <= 64'(zy2_reg[r]) * 64'(nsx_c_reg);
                m2a_reg[r]   <= 64'(zy1_reg[r]) * 64'(sx_c_reg);
                m2b_reg[r]   <= 64'(zy2_reg[r]) * 64'(cx_c_reg);
                r0_reg[r]    <= zy0_d_reg[r];
                r1_reg[r]    <= round_sat(65'(m1a_reg[r]) + 65'(m1b_reg[r]));
                r2_reg[r]    <= round_sat(65'(m2a_reg[r]) + 65'(m2b_reg[r]));
            end
        end
    end

    // ---- column serializer -------------------------------------------------
    logic signed [31:0] mat_reg [3][3];
    pos_t               mpos_reg;

    assign fire       = ser_valid_reg && !column_stall;
    assign done       = fire && (col_reg == LAST_COL);
    assign load       = v_reg[NST-1] && (!ser_valid_reg || done);
    assign adv        = !v_reg[NST-1] || load;
    assign item_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            col_reg       <= '0;
        end
        else if (load)
        begin
            ser_valid_reg <= 1'b1;
            col_reg       <= '0;
        end
        else if (fire)
        begin
            col_reg <= col_reg + 2'd1;
            if (done)
                ser_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int r = 0; r < 3; r++)
            begin
                mat_reg[0][r] <= r0_reg[r];
                mat_reg[1][r] <= r1_reg[r];
                mat_reg[2][r] <= r2_reg[r];
            end
            mpos_reg <= pos_reg[NST-1];
        end
    end

    always_comb
    begin
        column.column_index = col_reg;
        column.last_column  = (col_reg == LAST_COL);
        if (col_reg == LAST_COL)
        begin
            column.entry_row0 = mpos_reg.pos_x;
            column.entry_row1 = mpos_reg.pos_y;
            column.entry_row2 = mpos_reg.pos_z;
            column.entry_row3 = ONE_Q16;
        end
        else
        begin
            column.entry_row0 = mat_reg[col_reg][0];
            column.entry_row1 = mat_reg[col_reg][1];
            column.entry_row2 = mat_reg[col_reg][2];
            column.entry_row3 = '0;
        end
    end

    assign column_valid = ser_valid_reg;

endmodule

`default_nettype wire

// File: src/vmfe_checker.sv
// ----------------------------------------------------------------------------
// vmfe_checker
// Port-level checks on the channels of the view matrix builder.
// ----------------------------------------------------------------------------
`default_nettype none

module vmfe_checker
    import vmfe_pkg::*;
(
    input wire     clk,
    input wire     rst_n,
    input wire     item_stall,
    input wire     column_valid,
    input wire     column_stall,
    input column_t column
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        column_valid && column_stall |=> column_valid && $stable(column))
        else $error("stalled column transaction changed");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        column_valid |-> column.last_column == (column.column_index == LAST_COL))
        else $error("last_column does not match column 3");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        column_valid && !column_stall && column.column_index != LAST_COL
        |=> column_valid && column.column_index == $past(column.column_index) + 2'd1)
        else $error("matrix columns not sent back to back in order");

    a_row3: assert property (@(posedge clk) disable iff (!rst_n)
        column_valid |-> (column.column_index == LAST_COL) ?
            (column.entry_row3 == ONE_Q16) : (column.entry_row3 == 32'sd0))
        else $error("row 3 entry wrong");

    // an idle output register always takes the next matrix
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !column_valid |-> !item_stall)
        else $error("item channel stalled with idle output");

endmodule

bind view_matrix_from_euler_angles vmfe_checker u_vmfe_checker (
    .clk(clk), .rst_n(rst_n),
    .item_stall(item_stall),
    .column_valid(column_valid), .column_stall(column_stall), .column(column)
);

`default_nettype wire
